FILE: design/complex_matrix_vector_multiply_top_assert.svh
// ----------------------------------------------------------------------------
// complex matrix vector multiply assertion macros
// shared property forms for the design modules
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define COMPLEX_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

// same-cycle implication
`define CMV_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cmv assertion failed");

// next-cycle implication
`define CMV_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cmv assertion failed");

`endif

FILE: design/cmv_pkg.sv
// ----------------------------------------------------------------------------
// cmv_pkg
// types and constants shared by the complex matrix vector multiply block
// ----------------------------------------------------------------------------
package cmv_pkg;

    localparam int VAL_W       = 16;
    localparam int IDX_W       = 8;
    localparam int ACC_W       = 42;
    localparam int PROD_W      = 32;
    localparam int LEN_W       = 9;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 96;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic {
        OP_VEC_WRITE = 1'b0,
        OP_MAT_ELEM  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } item_t;

endpackage

FILE: design/cmv_front.sv
// ----------------------------------------------------------------------------
// cmv_front
// input stage: takes requests, classifies them and hands them to the queue
// ----------------------------------------------------------------------------
module cmv_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cmv_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              q_wr_valid,
    input  logic                              q_wr_ready,
    output cmv_pkg::item_t                    q_wr_data
);
    import cmv_pkg::*;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    item_t item_in;
    logic  take;
    logic  push;

    always_comb begin
        item_in.op  = s_tuser ? OP_MAT_ELEM : OP_VEC_WRITE;
        item_in.idx = s_tdata[7:0];
        item_in.re  = s_tdata[23:8];
        item_in.im  = s_tdata[39:24];
    end

    assign push     = stage_valid_reg && q_wr_ready;
    assign s_tready = !stage_valid_reg || q_wr_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (take) begin
            stage_valid_next = 1'b1;
        end else if (push) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            stage_item_reg <= item_in;
        end
    end

    assign q_wr_valid = stage_valid_reg;
    assign q_wr_data  = stage_item_reg;

endmodule

FILE: design/cmv_queue.sv
// ----------------------------------------------------------------------------
// cmv_queue
// short fifo between the front and back parts
// ----------------------------------------------------------------------------
`include "complex_matrix_vector_multiply_top_assert.svh"

module cmv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  cmv_pkg::item_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output cmv_pkg::item_t rd_data
);
    import cmv_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `CMV_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `CMV_ASSERT_IMPL(a_empty_ptrs, count_reg == '0, wr_ptr_reg == rd_ptr_reg)
    `CMV_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1))

endmodule

FILE: design/cmv_back.sv
// ----------------------------------------------------------------------------
// cmv_back
// vector store, column/row counters, complex multiply and row accumulation
// ----------------------------------------------------------------------------
`include "complex_matrix_vector_multiply_top_assert.svh"

module cmv_back #(
    parameter int MAX_SIZE = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [cmv_pkg::LEN_W-1:0]          cfg_len,
    input  logic                               q_rd_valid,
    output logic                               q_rd_ready,
    input  cmv_pkg::item_t                     q_rd_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cmv_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);
    import cmv_pkg::*;

    localparam int AW      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW      = $clog2(MAX_SIZE + 1);
    localparam int N_RESET = (MAX_SIZE < 256) ? MAX_SIZE : 256;
    localparam int PAD_W   = OUT_TDATA_W - IDX_W - 2 * ACC_W;

    // effective length register
    logic [NW-1:0] n_reg;
    logic [NW-1:0] n_next;

    // issue stage
    logic          en;
    logic          pop;
    logic          is_write;
    logic          vidx_ok;
    logic          col_end;
    logic          row_last;
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [AW-1:0] row_reg;
    logic [AW-1:0] row_next;

    logic [2*VAL_W-1:0] mem [MAX_SIZE];
    logic [2*VAL_W-1:0] rd_reg;

    // stage 1
    logic                    s1_valid_reg;
    logic                    s1_clear_reg;
    logic                    s1_end_reg;
    logic                    s1_last_reg;
    logic [IDX_W-1:0]        s1_row_reg;
    logic signed [VAL_W-1:0] s1_are_reg;
    logic signed [VAL_W-1:0] s1_aim_reg;
    logic signed [VAL_W-1:0] bre;
    logic signed [VAL_W-1:0] bim;

    // stage 2
    logic                     s2_valid_reg;
    logic                     s2_clear_reg;
    logic                     s2_end_reg;
    logic                     s2_last_reg;
    logic [IDX_W-1:0]         s2_row_reg;
    logic signed [PROD_W-1:0] p_rr_reg;
    logic signed [PROD_W-1:0] p_ii_reg;
    logic signed [PROD_W-1:0] p_ri_reg;
    logic signed [PROD_W-1:0] p_ir_reg;

    // accumulate and output
    logic signed [PROD_W:0]  term_re;
    logic signed [PROD_W:0]  term_im;
    logic signed [ACC_W-1:0] sum_re;
    logic signed [ACC_W-1:0] sum_im;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_re_next;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic signed [ACC_W-1:0] acc_im_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_load;
    logic [IDX_W-1:0]        out_row_reg;
    logic signed [ACC_W-1:0] out_re_reg;
    logic signed [ACC_W-1:0] out_im_reg;
    logic                    out_last_reg;

    always_comb begin
        n_next = n_reg;
        if (cfg_we) begin
            if (cfg_len == '0) begin
                n_next = NW'(1);
            end else if (32'(cfg_len) > MAX_SIZE) begin
                n_next = NW'(MAX_SIZE);
            end else begin
                n_next = NW'(cfg_len);
            end
        end
    end

    assign en         = !out_valid_reg || m_tready;
    assign q_rd_ready = en;
    assign pop        = q_rd_valid && en;
    assign is_write   = (q_rd_data.op == OP_VEC_WRITE);
    assign vidx_ok    = (32'(q_rd_data.idx) < MAX_SIZE);
    assign col_end    = (NW'(col_reg) + NW'(1)) >= n_reg;
    assign row_last   = (NW'(row_reg) + NW'(1)) >= n_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pop) begin
            if (is_write) begin
                col_next = '0;
                row_next = '0;
            end else if (col_end) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + AW'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && is_write && vidx_ok) begin
            mem[AW'(q_rd_data.idx)] <= {q_rd_data.im, q_rd_data.re};
        end
        if (en) begin
            rd_reg <= mem[col_reg];
        end
    end

    assign bre = rd_reg[VAL_W-1:0];
    assign bim = rd_reg[2*VAL_W-1:VAL_W];

    always_ff @(posedge aclk) begin
        if (en && pop) begin
            s1_clear_reg <= is_write;
            s1_end_reg   <= !is_write && col_end;
            s1_last_reg  <= row_last;
            s1_row_reg   <= IDX_W'(row_reg);
            s1_are_reg   <= q_rd_data.re;
            s1_aim_reg   <= q_rd_data.im;
        end
        if (en) begin
            s2_clear_reg <= s1_clear_reg;
            s2_end_reg   <= s1_end_reg;
            s2_last_reg  <= s1_last_reg;
            s2_row_reg   <= s1_row_reg;
            p_rr_reg     <= s1_are_reg * bre;
            p_ii_reg     <= s1_aim_reg * bim;
            p_ri_reg     <= s1_are_reg * bim;
            p_ir_reg     <= s1_aim_reg * bre;
        end
    end

    assign term_re = (PROD_W+1)'(p_rr_reg) - (PROD_W+1)'(p_ii_reg);
    assign term_im = (PROD_W+1)'(p_ri_reg) + (PROD_W+1)'(p_ir_reg);
    assign sum_re  = acc_re_reg + ACC_W'(term_re);
    assign sum_im  = acc_im_reg + ACC_W'(term_im);

    always_comb begin
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        if (en) begin
            out_valid_next = 1'b0;
            if (s2_valid_reg) begin
                if (s2_clear_reg) begin
                    acc_re_next = '0;
                    acc_im_next = '0;
                end else if (s2_end_reg) begin
                    acc_re_next    = '0;
                    acc_im_next    = '0;
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                end else begin
                    acc_re_next = sum_re;
                    acc_im_next = sum_im;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= NW'(N_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            n_reg         <= n_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            acc_re_reg    <= acc_re_next;
            acc_im_reg    <= acc_im_next;
            out_valid_reg <= out_valid_next;
            if (en) begin
                s1_valid_reg <= pop;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg  <= s2_row_reg;
            out_re_reg   <= sum_re;
            out_im_reg   <= sum_im;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_im_reg, out_re_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    `CMV_ASSERT_NEXT(a_stall_holds_acc, out_valid_reg && !m_tready, $stable(acc_re_reg) && $stable(acc_im_reg))
    `CMV_ASSERT_IMPL(a_clear_not_end, s1_valid_reg && s1_clear_reg, !s1_end_reg)
    `CMV_ASSERT_NEXT(a_write_restarts, pop && is_write, col_reg == '0 && row_reg == '0)

endmodule

FILE: design/complex_matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// complex_matrix_vector_multiply_top
// square complex matrix times stored complex vector, one row sum per row
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries requests; s_tuser = 0 writes vector entry
//   s_tdata[7:0] with s_tdata[39:24]/s_tdata[23:8] (im/re, q1.15) and restarts
//   the row/column counters; s_tuser = 1 streams one matrix element, row-major
//   m_ channel returns one q12.30 row sum per completed row, m_tlast on the
//   final row; cfg_ channel sets the matrix dimension, written while idle
//   throughput: one request per cycle while the receiver does not stall, set by the single complex
//   multiply-accumulate unit in the back part
//   a row sum shows on m_tvalid once the row's last element has passed the input
//   stage, the queue, the store read and multiply stages and the output register
//   reset clears counters, accumulators and length (MAX_SIZE, at most 256);
//   vector store contents are undefined until written
//   a receiver stall holds the result and the back part; the 4-entry queue
//   and input stage keep taking requests until full, then s_tready drops
// ----------------------------------------------------------------------------
module complex_matrix_vector_multiply_top #(
    parameter int MAX_SIZE = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config: dimension in use
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cmv_pkg::LEN_W-1:0]          cfg_data,
    // tdata: vector_index[7:0], value_re[23:8], value_im[39:24]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cmv_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: mode[0]
    input  logic                               s_tuser,
    // tdata: row_index[7:0], sum_re[49:8], sum_im[91:50], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cmv_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);
    import cmv_pkg::*;

    logic  q_wr_valid;
    logic  q_wr_ready;
    item_t q_wr_data;
    logic  q_rd_valid;
    logic  q_rd_ready;
    item_t q_rd_data;

    assign cfg_ready = 1'b1;

    cmv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_data  (q_wr_data)
    );

    cmv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    cmv_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_len    (cfg_data),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_data  (q_rd_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
